// ----- rtl/bhte_pkg.sv -----
// Shared types and constants of the bucketed hash table engine.
package bhte_pkg;

  localparam int unsigned BUCKET_COUNT     = 256;
  localparam int unsigned SLOTS_PER_BUCKET = 4;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned BKT_IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned SLOT_IDX_W =
      (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  localparam logic [BKT_IDX_W-1:0] BKT_MASK = BKT_IDX_W'(BUCKET_COUNT - 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // One bucket as one memory word: valid marks, keys and values of all slots.
  typedef struct packed {
    logic [SLOTS_PER_BUCKET-1:0]              valid;
    logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0]   key;
    logic [SLOTS_PER_BUCKET-1:0][VALUE_W-1:0] value;
  } bkt_row_t;

  // Outcome of one operation on a bucket.
  typedef struct packed {
    logic               wr;
    logic [VALUE_W-1:0] value;
    status_e            status;
  } bkt_res_t;

endpackage

// ----- rtl/bucketed_hash_table_engine_unit.sv -----
// Top level of the bucketed hash table engine: bucket memory, pipeline and result register.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | operation_i, key_i, value_in_i
//   out     | output    | out_valid_o / out_ready_i| value_out_o, status_o
//
// An item accepted at the input is held in the compare stage, and its result is written to the
// output register when that stage moves on. One item per cycle is sustained while the output is
// taken; the bucket memory takes one read and one write of a whole bucket row in every cycle.
// Reset clears the per-row written marks at once, so a never-written row reads as all free.
// When the output register is full and not taken, the compare stage holds its item and the
// input stalls; the input is open whenever the compare stage is empty or moving on.
module bucketed_hash_table_engine_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bhte_pkg::OP_W-1:0]        operation_i,
  input  logic [bhte_pkg::KEY_W-1:0]       key_i,
  input  logic [bhte_pkg::VALUE_W-1:0]     value_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bhte_pkg::VALUE_W-1:0]     value_out_o,
  output logic [bhte_pkg::STATUS_W-1:0]    status_o
);

  // Bucket memory: one row per bucket, read and written as a whole.
  bhte_pkg::bkt_row_t bkt_mem [bhte_pkg::BUCKET_COUNT];

  // A row's slot marks count only once that row has been written since reset.
  logic [bhte_pkg::BUCKET_COUNT-1:0] row_written_q, row_written_d;

  // Compare stage: the item whose bucket row has been read into rd_row_q.
  logic                              s1_valid_q, s1_valid_d;
  logic [bhte_pkg::OP_W-1:0]         s1_op_q;
  logic [bhte_pkg::KEY_W-1:0]        s1_key_q;
  logic [bhte_pkg::VALUE_W-1:0]      s1_value_q;
  logic [bhte_pkg::BKT_IDX_W-1:0]    s1_idx_q;
  bhte_pkg::bkt_row_t                rd_row_q;

  // Last row written, forwarded to an item that read the same row at that very edge.
  logic                              fwd_valid_q, fwd_valid_d;
  logic [bhte_pkg::BKT_IDX_W-1:0]    fwd_idx_q;
  bhte_pkg::bkt_row_t                fwd_row_q;

  // Output register.
  logic                              out_valid_q, out_valid_d;
  logic [bhte_pkg::VALUE_W-1:0]      out_value_q;
  logic [bhte_pkg::STATUS_W-1:0]     out_status_q;

  logic                              in_fire;
  logic                              s1_adv;
  logic [bhte_pkg::BKT_IDX_W-1:0]    in_idx;
  bhte_pkg::bkt_row_t                cur_row;
  bhte_pkg::bkt_row_t                new_row;
  bhte_pkg::bkt_res_t                res;
  logic                              mem_we;

  assign in_idx = key_i[bhte_pkg::BKT_IDX_W-1:0] & bhte_pkg::BKT_MASK;

  // The compare stage moves on when the output register is empty or being emptied.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Pick the freshest copy of the bucket row.
  always_comb begin
    if (fwd_valid_q && (fwd_idx_q == s1_idx_q)) begin
      cur_row = fwd_row_q;
    end else if (row_written_q[s1_idx_q]) begin
      cur_row = rd_row_q;
    end else begin
      cur_row = '0;
    end
  end

  bhte_slot_match u_slot_match (
    .row_i      (cur_row),
    .op_i       (s1_op_q),
    .key_i      (s1_key_q),
    .value_in_i (s1_value_q),
    .row_o      (new_row),
    .res_o      (res)
  );

  assign mem_we = s1_adv && res.wr;

  always_comb begin
    s1_valid_d    = s1_valid_q;
    out_valid_d   = out_valid_q;
    fwd_valid_d   = fwd_valid_q;
    row_written_d = row_written_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      fwd_valid_d = res.wr;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
    if (mem_we) begin
      row_written_d[s1_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      fwd_valid_q   <= 1'b0;
      row_written_q <= '0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
      fwd_valid_q   <= fwd_valid_d;
      row_written_q <= row_written_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= operation_i;
      s1_key_q   <= key_i;
      s1_value_q <= value_in_i;
      s1_idx_q   <= in_idx;
    end
    if (s1_adv) begin
      out_value_q  <= res.value;
      out_status_q <= res.status;
      fwd_idx_q    <= s1_idx_q;
      fwd_row_q    <= new_row;
    end
  end

  // Bucket memory port: a read at the address being written returns the old row.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bkt_mem[s1_idx_q] <= new_row;
    end
    if (in_fire) begin
      rd_row_q <= bkt_mem[in_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign status_o    = out_status_q;

endmodule

// ----- rtl/bhte_slot_match.sv -----
// Slot compare and update logic for one bucket row of the hash table engine.
module bhte_slot_match (
  input  bhte_pkg::bkt_row_t                row_i,
  input  logic [bhte_pkg::OP_W-1:0]         op_i,
  input  logic [bhte_pkg::KEY_W-1:0]        key_i,
  input  logic [bhte_pkg::VALUE_W-1:0]      value_in_i,
  output bhte_pkg::bkt_row_t                row_o,
  output bhte_pkg::bkt_res_t                res_o
);

  logic [bhte_pkg::SLOTS_PER_BUCKET-1:0] hit;
  logic                                  any_hit;
  logic                                  any_free;
  logic [bhte_pkg::SLOT_IDX_W-1:0]       hit_idx;
  logic [bhte_pkg::SLOT_IDX_W-1:0]       free_idx;

  // Lowest matching slot and lowest free slot.
  always_comb begin
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < bhte_pkg::SLOTS_PER_BUCKET; i++) begin
      hit[i] = row_i.valid[i] && (row_i.key[i] == key_i);
    end
    for (int i = bhte_pkg::SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = bhte_pkg::SLOT_IDX_W'(i);
      end
      if (!row_i.valid[i]) begin
        any_free = 1'b1;
        free_idx = bhte_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    row_o        = row_i;
    res_o.wr     = 1'b0;
    res_o.value  = '0;
    res_o.status = bhte_pkg::ST_ABSENT;
    case (op_i)
      bhte_pkg::OP_LOOKUP: begin
        if (any_hit) begin
          res_o.value  = row_i.value[hit_idx];
          res_o.status = bhte_pkg::ST_OK;
        end
      end
      bhte_pkg::OP_INSERT: begin
        if (any_hit) begin
          res_o.status = bhte_pkg::ST_PRESENT;
        end else if (!any_free) begin
          res_o.status = bhte_pkg::ST_FULL;
        end else begin
          row_o.key[free_idx]   = key_i;
          row_o.value[free_idx] = value_in_i;
          row_o.valid[free_idx] = 1'b1;
          res_o.wr              = 1'b1;
          res_o.status          = bhte_pkg::ST_OK;
        end
      end
      bhte_pkg::OP_REMOVE: begin
        if (any_hit) begin
          row_o.valid[hit_idx] = 1'b0;
          res_o.value          = row_i.value[hit_idx];
          res_o.wr             = 1'b1;
          res_o.status         = bhte_pkg::ST_OK;
        end
      end
      default: begin
        res_o.status = bhte_pkg::ST_ABSENT;
      end
    endcase
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench of the bucketed hash table engine with a predicting table copy.
`timescale 1ns / 1ps

module tb;
  import bhte_pkg::*;

  localparam int unsigned TABLE_SLOTS = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned POOL_KEYS = 40;
  localparam int unsigned HOT_BUCKETS = 8;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } table_req_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_e            status;
  } table_resp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     operation_i = '0;
  logic [KEY_W-1:0]    key_i = '0;
  logic [VALUE_W-1:0]  value_in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [VALUE_W-1:0]  value_out_o;
  logic [STATUS_W-1:0] status_o;

  table_req_t  req_queue[$];
  table_resp_t owed_resps[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Shadow copy of the table, updated as items are accepted.
  logic               shadow_valid[TABLE_SLOTS];
  logic [KEY_W-1:0]   shadow_key[TABLE_SLOTS];
  logic [VALUE_W-1:0] shadow_value[TABLE_SLOTS];

  logic [KEY_W-1:0] key_pool[POOL_KEYS];

  bucketed_hash_table_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_out_o (value_out_o),
    .status_o    (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Applies one operation to the shadow table and returns the result it should produce.
  function automatic table_resp_t apply_table_op(table_req_t req);
    table_resp_t resp;
    int unsigned base;
    int          hit;
    int          free_idx;
    base = int'(req.key & KEY_W'(BUCKET_COUNT - 1)) * SLOTS_PER_BUCKET;
    hit = -1;
    free_idx = -1;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (shadow_valid[base + i] && shadow_key[base + i] == req.key) hit = base + i;
      if (!shadow_valid[base + i]) free_idx = base + i;
    end
    resp.value = '0;
    resp.status = ST_ABSENT;
    case (req.op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          resp.value = shadow_value[hit];
          resp.status = ST_OK;
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          resp.status = ST_PRESENT;
        end else if (free_idx < 0) begin
          resp.status = ST_FULL;
        end else begin
          shadow_valid[free_idx] = 1'b1;
          shadow_key[free_idx] = req.key;
          shadow_value[free_idx] = req.value;
          resp.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          resp.value = shadow_value[hit];
          shadow_valid[hit] = 1'b0;
          resp.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  function automatic logic [KEY_W-1:0] key_in_bucket(logic [KEY_W-1:0] upper,
                                                     int unsigned bkt);
    return (upper << BKT_IDX_W) | KEY_W'(bkt);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [VALUE_W-1:0] value);
    table_req_t req;
    req.op = op;
    req.key = key;
    req.value = value;
    req_queue.push_back(req);
  endtask

  // Keys crowd into a few buckets, more keys than slots, so that hits, duplicates and
  // full buckets are common. A tenth reuse a hot bucket with fresh upper bits and a
  // tenth are fully random.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return key_pool[$urandom_range(POOL_KEYS - 1)];
    if (roll < 90) begin
      return (rand64() & ~KEY_W'(BUCKET_COUNT - 1)) |
             (key_pool[$urandom_range(POOL_KEYS - 1)] & KEY_W'(BUCKET_COUNT - 1));
    end
    return rand64();
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 15) return '1;
    return rand64();
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return OP_INSERT;
    if (roll < 70) return OP_LOOKUP;
    if (roll < 95) return OP_REMOVE;
    return OP_UNUSED;
  endfunction

  task automatic refill_key_pool();
    int unsigned hot[HOT_BUCKETS];
    foreach (hot[i]) hot[i] = $urandom_range(BUCKET_COUNT - 1);
    foreach (key_pool[i]) key_pool[i] = key_in_bucket(rand64(), hot[i % HOT_BUCKETS]);
  endtask

  // Waits until every item has gone in and every result has come back.
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid_i || owed_resps.size() != 0) @(negedge clk_i);
  endtask

  // Driver: an item stays on the bus until accepted; the next one may follow at once.
  always @(posedge clk_i) begin
    table_req_t req;
    logic       holding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      holding = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        req.op = operation_i;
        req.key = key_i;
        req.value = value_in_i;
        owed_resps.push_back(apply_table_op(req));
      end
      if (!holding) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = req_queue.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= req.op;
          key_i       <= req.key;
          value_in_i  <= req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: every accepted result is matched against the oldest owed one.
  always @(posedge clk_i) begin
    table_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_resps.size() == 0) begin
        $error("result with no item waiting: value_out %h, status %0d", value_out_o,
               status_o);
        mismatch_count++;
      end else begin
        want = owed_resps.pop_front();
        if (value_out_o !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, value_out_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] ka, kb, kc, kd, ke;
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: zero key and value, all-ones key and value, one bucket filled to
    // the brim, duplicates, removal and reuse of the freed slot, the unused code, and a
    // key that differs from a stored one only in its top bit.
    ka = key_in_bucket(64'd1, 5);
    kb = key_in_bucket(64'd2, 5);
    kc = key_in_bucket(64'd3, 5);
    kd = key_in_bucket(64'h0080_0000_0000_0000, 5);
    ke = key_in_bucket(64'd4, 5);
    queue_req(OP_LOOKUP, '0, '1);
    queue_req(OP_INSERT, '0, '0);
    queue_req(OP_LOOKUP, '0, '0);
    queue_req(OP_INSERT, '0, 64'hff);
    queue_req(OP_INSERT, '1, '1);
    queue_req(OP_LOOKUP, '1, '0);
    queue_req(OP_INSERT, ka, 64'h1111_2222_3333_4444);
    queue_req(OP_INSERT, kb, 64'h5555_6666_7777_8888);
    queue_req(OP_INSERT, kc, 64'h9999_aaaa_bbbb_cccc);
    queue_req(OP_INSERT, kd, 64'hdddd_eeee_ffff_0000);
    queue_req(OP_INSERT, ke, 64'h0123_4567_89ab_cdef);
    queue_req(OP_INSERT, kb, 64'h0);
    queue_req(OP_LOOKUP, ke, '0);
    queue_req(OP_REMOVE, kb, '1);
    queue_req(OP_REMOVE, kb, '0);
    queue_req(OP_INSERT, ke, 64'hfedc_ba98_7654_3210);
    queue_req(OP_LOOKUP, ke, '0);
    queue_req(OP_LOOKUP, kc, '0);
    queue_req(OP_UNUSED, ka, '1);
    queue_req(OP_LOOKUP, ka, '0);
    queue_req(OP_REMOVE, '1, '0);
    queue_req(OP_LOOKUP, '1, '0);
    queue_req(OP_LOOKUP, ka ^ (64'd1 << 63), '0);
    wait_drained();

    // Random phases, each started with the pipeline empty.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      refill_key_pool();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) queue_req(pick_op(), pick_key(), pick_value());
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && owed_resps.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
